>>> design/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants for the key click classifier
// Holds tick counter sizing, the click phase and event code types, and the
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package kcc_pkg;

  // Width of the press and release tick counters (4 to 16).
  localparam int TICK_COUNT_BITS = 8;
  localparam int CFG_DATA_W      = 8;
  localparam int CFG_INDEX_W     = 2;
  localparam int CLICK_W         = 3;
  localparam int EVENT_W         = 3;

  // Counters and thresholds are compared at the wider of the two widths.
  localparam int CMP_W = (TICK_COUNT_BITS > CFG_DATA_W) ? TICK_COUNT_BITS : CFG_DATA_W;

  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX  = '1;
  localparam logic [CLICK_W-1:0]         CLICK_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] FILTER_RST = CFG_DATA_W'(2);
  localparam logic [CFG_DATA_W-1:0] LONG_RST   = CFG_DATA_W'(150);
  localparam logic [CFG_DATA_W-1:0] GAP_RST    = CFG_DATA_W'(30);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FILTER = 2'd0,
    CFG_LONG   = 2'd1,
    CFG_GAP    = 2'd2,
    CFG_MULTI  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HELD = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

endpackage

`default_nettype wire

>>> design/key_click_classifier.sv
// ----------------------------------------------------------------------------
// key_click_classifier: debounced click, multi-click and long-press detector
// Takes one key level sample per transfer and returns one event code per
// sample: none, single, double or triple click, or long press.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_valid / in_stall  in_key_level  (1 bit)
//   out_     out  out_valid/ out_stall out_event_code (3 bits)
//   cfg_     in   cfg_we               cfg_index (2 bits), cfg_wdata (8 bits)
//
// Each sample is classified in the cycle it is accepted, and its event code
// sits in the output register from the next cycle on.
// One sample per cycle is taken while the output register is empty or being
// drained; in_stall is high only while a held result is stalled.
// Reset (synchronous, rst_n low) clears all tick state and loads the
// register defaults: filter 2, long 150, gap 30, multi-click on.
// ----------------------------------------------------------------------------
`default_nettype none

module key_click_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_key_level,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [kcc_pkg::EVENT_W-1:0]   out_event_code,
  input  wire logic                          cfg_we,
  input  wire logic [kcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kcc_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] filter_ticks_r;
  logic [CFG_DATA_W-1:0] long_ticks_r;
  logic [CFG_DATA_W-1:0] gap_ticks_r;
  logic                  multi_click_enable_r;

  // Classifier state.
  logic [TICK_COUNT_BITS-1:0] press_ticks_r, press_ticks_nxt;
  logic [TICK_COUNT_BITS-1:0] release_ticks_r, release_ticks_nxt;
  phase_t                     phase_r, phase_nxt;
  logic                       long_reported_r, long_reported_nxt;
  logic [CLICK_W-1:0]         click_count_r, click_count_nxt;

  // Output register.
  logic   out_valid_r;
  event_t event_r;
  event_t event_nxt;

  logic in_xfer;

  logic [TICK_COUNT_BITS-1:0] press_inc;
  logic [TICK_COUNT_BITS-1:0] release_inc;
  logic                       filter_met, long_met, gap_met;
  phase_t                     phase_rel;

  // A new sample is taken unless a finished result is stalled.
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Saturating increments and threshold compares.
  assign press_inc   = (press_ticks_r == TICK_MAX) ? TICK_MAX : press_ticks_r + 1'b1;
  assign release_inc = (release_ticks_r == TICK_MAX) ? TICK_MAX : release_ticks_r + 1'b1;
  assign filter_met  = CMP_W'(press_inc) >= CMP_W'(filter_ticks_r);
  assign long_met    = CMP_W'(press_inc) >= CMP_W'(long_ticks_r);
  assign gap_met     = CMP_W'(release_inc) >= CMP_W'(gap_ticks_r);
  assign phase_rel   = (phase_r == PH_HELD) ? PH_GAP : phase_r;

  // Next state and event for one sample.
  always_comb begin
    press_ticks_nxt   = press_ticks_r;
    release_ticks_nxt = release_ticks_r;
    phase_nxt         = phase_r;
    long_reported_nxt = long_reported_r;
    click_count_nxt   = click_count_r;
    event_nxt         = EV_NONE;
    if (in_key_level) begin
      release_ticks_nxt = '0;
      press_ticks_nxt   = press_inc;
      if (filter_met) begin
        if (phase_r != PH_HELD) begin
          phase_nxt       = PH_HELD;
          click_count_nxt = (click_count_r == CLICK_MAX) ? CLICK_MAX
                                                         : click_count_r + 1'b1;
        end
        if (long_met && !long_reported_r) begin
          long_reported_nxt = 1'b1;
          event_nxt         = EV_LONG;
          click_count_nxt   = '0;
        end
      end
    end else begin
      press_ticks_nxt   = '0;
      long_reported_nxt = 1'b0;
      if (multi_click_enable_r) begin
        phase_nxt = phase_rel;
        if (phase_rel == PH_GAP) begin
          release_ticks_nxt = release_inc;
          if (gap_met) begin
            phase_nxt         = PH_IDLE;
            release_ticks_nxt = '0;
            click_count_nxt   = '0;
            // Four or more clicks give no event.
            if (click_count_r != '0 && click_count_r <= CLICK_W'(EV_TRIPLE)) begin
              event_nxt = event_t'(click_count_r);
            end
          end
        end
      end else begin
        phase_nxt         = PH_IDLE;
        release_ticks_nxt = '0;
        click_count_nxt   = '0;
        if (click_count_r != '0) begin
          event_nxt = EV_SINGLE;
        end
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_ticks_r       <= FILTER_RST;
      long_ticks_r         <= LONG_RST;
      gap_ticks_r          <= GAP_RST;
      multi_click_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FILTER: filter_ticks_r       <= cfg_wdata;
        CFG_LONG:   long_ticks_r         <= cfg_wdata;
        CFG_GAP:    gap_ticks_r          <= cfg_wdata;
        CFG_MULTI:  multi_click_enable_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // State update on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= '0;
      release_ticks_r <= '0;
      phase_r         <= PH_IDLE;
      long_reported_r <= 1'b0;
      click_count_r   <= '0;
    end else if (in_xfer) begin
      press_ticks_r   <= press_ticks_nxt;
      release_ticks_r <= release_ticks_nxt;
      phase_r         <= phase_nxt;
      long_reported_r <= long_reported_nxt;
      click_count_r   <= click_count_nxt;
    end
  end

  // Output register: loads on input transfer, empties on output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      event_r <= event_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = event_r;

endmodule

`default_nettype wire

>>> design/kcc_checker.sv
// ----------------------------------------------------------------------------
// kcc_checker: port-level checks for the key click classifier
// Watches the top level's ports for result ordering, backpressure and event
// code range, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [kcc_pkg::EVENT_W-1:0]     out_event_code
);
  import kcc_pkg::*;

  // Every accepted sample has a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("kcc: accepted sample produced no result");

  // The input is held off only while a result is stalled.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("kcc: in_stall does not follow output backpressure");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code))
    else $error("kcc: stalled result changed");

  // Event codes stay within the defined set.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= EVENT_W'(EV_LONG))
    else $error("kcc: undefined event code");

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (.*);

`default_nettype wire
